// ----- rtl/core/aadf_pkg.sv -----
// shared types, control program and decimal helpers for the ascii decimal framer
`default_nettype none

package aadf_pkg;

	localparam int PROG_LEN = 9;
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(PROG_LEN);
	localparam logic [STEP_W-1:0] STEP_END = STEP_W'(PROG_LEN - 1);

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_SEP   = 3'd2;
	localparam logic [2:0] OP_DIGIT = 3'd3;
	localparam logic [2:0] OP_END   = 3'd4;

	localparam logic [2:0] COND_ALWAYS = 3'd0;
	localparam logic [2:0] COND_VALID  = 3'd1;
	localparam logic [2:0] COND_FIRST  = 3'd2;
	localparam logic [2:0] COND_ROOM   = 3'd3;
	localparam logic [2:0] COND_ENDING = 3'd4;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_SEP   = 2'd1;
	localparam logic [1:0] REG_END   = 2'd2;
	localparam logic [1:0] REG_MAX   = 2'd3;

	localparam logic [7:0] ASCII_ZERO = 8'h30;

	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
		logic [2:0]        pow_sel;
	} ctrl_word_t;

	// control program: target is taken when the condition fails
	function automatic ctrl_word_t prog_word(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_DONE, pow_sel: 3'd0};
		case (step)
			4'd0: w = '{op: OP_NONE,  cond: COND_VALID,  target: STEP_DONE, pow_sel: 3'd0};
			4'd1: w = '{op: OP_START, cond: COND_FIRST,  target: 4'd2,      pow_sel: 3'd0};
			4'd2: w = '{op: OP_SEP,   cond: COND_ALWAYS, target: 4'd3,      pow_sel: 3'd0};
			4'd3: w = '{op: OP_DIGIT, cond: COND_ROOM,   target: STEP_END,  pow_sel: 3'd4};
			4'd4: w = '{op: OP_DIGIT, cond: COND_ROOM,   target: STEP_END,  pow_sel: 3'd3};
			4'd5: w = '{op: OP_DIGIT, cond: COND_ROOM,   target: STEP_END,  pow_sel: 3'd2};
			4'd6: w = '{op: OP_DIGIT, cond: COND_ROOM,   target: STEP_END,  pow_sel: 3'd1};
			4'd7: w = '{op: OP_DIGIT, cond: COND_ROOM,   target: STEP_END,  pow_sel: 3'd0};
			4'd8: w = '{op: OP_END,   cond: COND_ENDING, target: STEP_DONE, pow_sel: 3'd0};
			default: w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_DONE, pow_sel: 3'd0};
		endcase
		return w;
	endfunction

	function automatic logic [16:0] pow_of(input logic [2:0] sel);
		logic [16:0] p;
		case (sel)
			3'd0: p = 17'd1;
			3'd1: p = 17'd10;
			3'd2: p = 17'd100;
			3'd3: p = 17'd1000;
			3'd4: p = 17'd10000;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

	// digit at the selected weight, remainder below ten times that weight
	function automatic logic [3:0] digit_of(input logic [16:0] rem, input logic [2:0] sel);
		logic [16:0] p;
		logic [3:0]  d;
		p = pow_of(sel);
		d = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem >= 17'(k) * p) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/adc_ascii_decimal_framer.sv -----
// ascii decimal framer: one 16-bit sample in, a delimited decimal text frame out
`default_nettype none

// Each accepted sample runs a nine-step control program, one step per cycle
// while no byte step is held back: a count check, the start byte (first
// sample of a message only), the separator, five decimal digit steps from the
// ten-thousands down, and the end byte (last sample only). A sample keeps
// in_ready low until its program is through, so no new sample is taken before
// then; the digit limit can cut the digit steps short, and a full output
// register with out_ready low holds a byte step back. A sample with a channel
// count of zero or above MSG_CHAN_LIMIT ends its program at the count check
// and yields no byte. Leading zero digits are skipped, and digits stop once
// the message byte count reaches max_len minus 2. Bytes leave through an
// output register, one per transfer. Configuration registers are start_char,
// separator_char, end_char and max_len at indexes 0 to 3 and must be written
// only while the block is idle.
module adc_ascii_decimal_framer
	import aadf_pkg::*;
#(
	parameter int MSG_CHAN_LIMIT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] sample_value,
	input  wire logic [3:0]  msg_chans,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             message_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0]        start_char_q, sep_char_q, end_char_q, max_len_q;
	logic              run_q;
	logic [STEP_W-1:0] step_q;
	logic [16:0]       rem_q;
	logic [3:0]        count_q;
	logic [3:0]        pos_q;
	logic [7:0]        bc_q;
	logic              seen_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q, out_end_q;

	ctrl_word_t        cw;
	logic [7:0]        limit;
	logic              room, ending, count_ok, cond_ok, signif, emit, go;
	logic [3:0]        dig;
	logic [16:0]       pow;
	logic [7:0]        bc_next;
	logic [STEP_W-1:0] nxt;
	logic [7:0]        byte_d;
	logic              last_d;

	assign cw       = prog_word(step_q);
	assign limit    = (max_len_q >= 8'd2) ? (max_len_q - 8'd2) : 8'd0;
	assign room     = bc_q < limit;
	assign ending   = ({1'b0, pos_q} + 5'd1) >= {1'b0, count_q};
	assign count_ok = (count_q != 4'd0) && (count_q <= 4'(MSG_CHAN_LIMIT));
	assign pow      = pow_of(cw.pow_sel);
	assign dig      = digit_of(rem_q, cw.pow_sel);
	assign signif   = (dig != 4'd0) || seen_q || (cw.pow_sel == 3'd0);
	assign bc_next  = (bc_q == 8'd255) ? 8'd255 : bc_q + 8'd1;

	always_comb begin
		unique case (cw.cond)
			COND_ALWAYS: cond_ok = 1'b1;
			COND_VALID:  cond_ok = count_ok;
			COND_FIRST:  cond_ok = (pos_q == 4'd0);
			COND_ROOM:   cond_ok = room;
			COND_ENDING: cond_ok = ending;
			default:     cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		byte_d = 8'd0;
		last_d = 1'b0;
		emit   = 1'b0;
		unique case (cw.op)
			OP_START: begin
				byte_d = start_char_q;
				emit   = cond_ok;
			end
			OP_SEP: begin
				byte_d = sep_char_q;
				last_d = !ending && (bc_next >= limit);
				emit   = 1'b1;
			end
			OP_DIGIT: begin
				byte_d = ASCII_ZERO + {4'd0, dig};
				last_d = !ending && ((cw.pow_sel == 3'd0) || (bc_next >= limit));
				emit   = cond_ok && signif;
			end
			OP_END: begin
				byte_d = end_char_q;
				last_d = 1'b1;
				emit   = cond_ok;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign go  = run_q && (!emit || !out_valid_q || out_ready);
	assign nxt = cond_ok ? (step_q + STEP_W'(1)) : cw.target;

	assign in_ready  = !run_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= 8'd36;
			sep_char_q   <= 8'd35;
			end_char_q   <= 8'd63;
			max_len_q    <= 8'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START: start_char_q <= cfg_data;
				REG_SEP:   sep_char_q   <= cfg_data;
				REG_END:   end_char_q   <= cfg_data;
				REG_MAX:   max_len_q    <= cfg_data;
				default:   max_len_q    <= max_len_q;
			endcase
		end
	end

	// sequencer and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			pos_q  <= 4'd0;
			bc_q   <= 8'd0;
			seen_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			run_q  <= 1'b1;
			step_q <= '0;
			seen_q <= 1'b0;
		end else if (go) begin
			step_q <= nxt;
			if (nxt == STEP_DONE) begin
				run_q <= 1'b0;
			end
			case (cw.op)
				OP_START: begin
					if (cond_ok) begin
						bc_q <= 8'd1;
					end
				end
				OP_SEP: bc_q <= bc_next;
				OP_DIGIT: begin
					if (emit) begin
						bc_q   <= bc_next;
						seen_q <= 1'b1;
					end
				end
				OP_END: begin
					if (ending) begin
						pos_q <= 4'd0;
						bc_q  <= 8'd0;
					end else begin
						pos_q <= pos_q + 4'd1;
					end
				end
				default: bc_q <= bc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q   <= {1'b0, sample_value};
			count_q <= msg_chans;
		end else if (go && (cw.op == OP_DIGIT)) begin
			rem_q <= rem_q - 17'(dig) * pow;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
			out_end_q  <= (cw.op == OP_END);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign message_end = out_end_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_end_q |-> out_last_q)
		else $error("end byte not marked last of run");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < 5'(MSG_CHAN_LIMIT))
		else $error("channel position beyond message length");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && (cw.op == OP_DIGIT) |-> rem_q < 17'd10 * pow)
		else $error("remainder too large for digit step");

	a_idle_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && go && (nxt == STEP_DONE) |=> !run_q)
		else $error("sequencer did not stop after last step");

endmodule

`default_nettype wire

// ----- tb/adc_ascii_decimal_framer_tb.sv -----
// self-checking testbench for the ascii decimal framer: random messages, stalls, register phases
`timescale 1ns / 1ps

module adc_ascii_decimal_framer_tb;
	import aadf_pkg::*;

	localparam int CHAN_LIMIT = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic [15:0] value;
		logic [3:0]  count;
	} sample_item_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       is_end;
	} frame_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] sample_value;
	logic [3:0]  msg_chans;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        message_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	sample_item_t samples_to_send[$];
	frame_byte_t  bytes_due[$];
	sample_item_t next_item;
	frame_byte_t  want;

	logic [7:0] start_ch = 8'd36;
	logic [7:0] sep_ch = 8'd35;
	logic [7:0] end_ch = 8'd63;
	logic [7:0] max_len_r = 8'd64;
	logic [3:0] chan_pos = 4'd0;
	logic [7:0] msg_bytes = 8'd0;

	logic item_taken = 1'b0;
	bit   idle_on = 1'b1;
	int   gap_left = 0;
	int   stall_left = 0;
	int   errors = 0;
	int   cycle_cnt = 0;

	adc_ascii_decimal_framer #(
		.MSG_CHAN_LIMIT(CHAN_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_value(sample_value),
		.msg_chans(msg_chans),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.message_end(message_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		errors++;
		$display("tb: %s mismatch at cycle %0d: got %0h, expected %0h",
			what, cycle_cnt, got, exp_val);
	endtask

	// bytes of the frame that one sample adds, with the message state advanced
	task automatic frame_sample(input logic [15:0] v, input logic [3:0] cnt);
		frame_byte_t run[$];
		logic [3:0]  digs[5];
		logic [15:0] rest;
		int          nd;
		int          lim;
		if (cnt == 4'd0 || int'(cnt) > CHAN_LIMIT)
			return;
		lim = (max_len_r >= 8'd2) ? int'(max_len_r) - 2 : 0;
		if (chan_pos == 4'd0) begin
			msg_bytes = 8'd0;
			run.push_back('{code: start_ch, last: 1'b0, is_end: 1'b0});
			if (msg_bytes != 8'hFF) msg_bytes++;
		end
		run.push_back('{code: sep_ch, last: 1'b0, is_end: 1'b0});
		if (msg_bytes != 8'hFF) msg_bytes++;
		rest = v;
		nd = 0;
		if (v == 16'd0) begin
			digs[0] = 4'd0;
			nd = 1;
		end
		while (rest != 16'd0) begin
			digs[nd] = 4'(rest % 16'd10);
			rest = rest / 16'd10;
			nd++;
		end
		for (int i = nd; i > 0; i--) begin
			if (int'(msg_bytes) < lim) begin
				run.push_back('{code: ASCII_ZERO + 8'(digs[i-1]), last: 1'b0, is_end: 1'b0});
				if (msg_bytes != 8'hFF) msg_bytes++;
			end
		end
		if (int'(chan_pos) + 1 >= int'(cnt)) begin
			run.push_back('{code: end_ch, last: 1'b0, is_end: 1'b1});
			chan_pos = 4'd0;
			msg_bytes = 8'd0;
		end else begin
			chan_pos = chan_pos + 4'd1;
		end
		run[run.size()-1].last = 1'b1;
		foreach (run[k]) bytes_due.push_back(run[k]);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 9));
			3: return 16'($urandom_range(10, 99));
			4: return 16'($urandom_range(100, 999));
			5: return 16'($urandom_range(1000, 9999));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void queue_sample(input logic [15:0] v, input logic [3:0] c);
		samples_to_send.push_back('{value: v, count: c});
	endfunction

	// mostly whole messages, some bad counts and messages cut short
	task automatic queue_random(input int n_valid);
		int made;
		int cnt;
		int k;
		made = 0;
		while (made < n_valid) begin
			case ($urandom_range(0, 9))
				0: queue_sample(rand_sample(), ($urandom_range(0, 1) != 0) ? 4'd0 :
					4'($urandom_range(CHAN_LIMIT + 1, 15)));
				1: begin
					cnt = $urandom_range(3, CHAN_LIMIT);
					k = $urandom_range(1, cnt - 2);
					for (int j = 0; j < k; j++) queue_sample(rand_sample(), 4'(cnt));
					queue_sample(rand_sample(), 4'($urandom_range(1, k)));
					made += k + 1;
				end
				default: begin
					cnt = $urandom_range(1, CHAN_LIMIT);
					for (int j = 0; j < cnt; j++) queue_sample(rand_sample(), 4'(cnt));
					made += cnt;
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (samples_to_send.size() != 0 || in_valid || bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [7:0] s, input logic [7:0] p,
			input logic [7:0] e, input logic [7:0] m);
		write_reg(REG_START, s);
		write_reg(REG_SEP, p);
		write_reg(REG_END, e);
		write_reg(REG_MAX, m);
	endtask

	// item channel and output ready
	always @(negedge clk) begin
		if (!in_valid || item_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (samples_to_send.size() != 0) begin
				next_item = samples_to_send.pop_front();
				sample_value <= next_item.value;
				msg_chans <= next_item.count;
				in_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
		end
	end

	// transfers seen at the rising edge
	always @(posedge clk) begin
		item_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START: start_ch = cfg_data;
					REG_SEP:   sep_ch = cfg_data;
					REG_END:   end_ch = cfg_data;
					REG_MAX:   max_len_r = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) frame_sample(sample_value, msg_chans);
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					report_mismatch("unexpected byte", out_byte, 8'd0);
				end else begin
					want = bytes_due.pop_front();
					if (out_byte !== want.code)
						report_mismatch("out_byte", out_byte, want.code);
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", 8'(last_of_run), 8'(want.last));
					if (message_end !== want.is_end)
						report_mismatch("message_end", 8'(message_end), 8'(want.is_end));
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_value = 16'd0;
		msg_chans = 4'd0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_START;
		cfg_data = 8'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 0) begin
				queue_sample(16'd0, 4'd1);
				queue_sample(16'hFFFF, 4'd1);
				queue_sample(16'd1, 4'd8);
				queue_sample(16'd9, 4'd8);
				queue_sample(16'd10, 4'd8);
				queue_sample(16'd99, 4'd8);
				queue_sample(16'd100, 4'd8);
				queue_sample(16'd999, 4'd8);
				queue_sample(16'd1000, 4'd8);
				queue_sample(16'd9999, 4'd8);
				// bad channel counts
				queue_sample(16'd12345, 4'd0);
				queue_sample(16'hFFFF, 4'd9);
				queue_sample(16'd0, 4'd15);
				// count shrinks mid-message
				queue_sample(16'd10000, 4'd4);
				queue_sample(16'd54321, 4'd4);
				queue_sample(16'd7, 4'd1);
				queue_sample(16'd10000, 4'd2);
				queue_sample(16'hFFFF, 4'd2);
			end else begin
				wait_idle();
				case (ph)
					1: write_all(8'h00, 8'hFF, 8'h00, 8'd3);
					2: write_all(8'hFF, 8'h00, 8'hFF, 8'd255);
					3: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'd1);
					4: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
					6: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'd64);
					default: write_all(8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom_range(3, 30)));
				endcase
			end
			idle_on = (ph == 0) || (ph != 6 && $urandom_range(0, 3) != 0);
			queue_random(30);
		end

		wait_idle();
		if (errors == 0 && bytes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
